// ----- sv/itps_pkg.sv -----
package itps_pkg;

  // time base width and configuration port geometry
  localparam int DEF_TIME_WIDTH = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int MS_W           = 32;
  localparam int BRIGHT_W       = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_AFTER       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_AFTER       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_AFTER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BRIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_BRIGHT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_POLL        = 3'd5;

  // register reset values
  localparam logic [MS_W-1:0]     RST_DIM_AFTER     = 32'd30000;
  localparam logic [MS_W-1:0]     RST_OFF_AFTER     = 32'd60000;
  localparam logic [MS_W-1:0]     RST_SLEEP_AFTER   = 32'd300000;
  localparam logic [BRIGHT_W-1:0] RST_ACTIVE_BRIGHT = 8'd255;
  localparam logic [BRIGHT_W-1:0] RST_DIM_BRIGHT    = 8'd64;
  localparam logic [MS_W-1:0]     RST_OFF_POLL      = 32'd1000;

  typedef enum logic [1:0] {
    LVL_ACTIVE = 2'd0,
    LVL_DIM    = 2'd1,
    LVL_OFF    = 2'd2,
    LVL_SLEEP  = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    ACT_ACTIVITY = 2'd0,
    ACT_UPDATE   = 2'd1,
    ACT_CLAIM    = 2'd2,
    ACT_RESTART  = 2'd3
  } action_t;

  typedef struct packed {
    logic [MS_W-1:0]     dim_after_ms;
    logic [MS_W-1:0]     display_off_after_ms;
    logic [MS_W-1:0]     light_sleep_after_ms;
    logic [BRIGHT_W-1:0] active_brightness;
    logic [BRIGHT_W-1:0] dim_brightness;
    logic [MS_W-1:0]     off_poll_interval_ms;
  } cfg_t;

endpackage

// ----- sv/itps_if.sv -----
interface itps_event_if;
  import itps_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [MS_W-1:0]     now_ms;
  logic                sleep_allowed;

  modport source (output valid, action, now_ms, sleep_allowed, input ready);
  modport sink   (input valid, action, now_ms, sleep_allowed, output ready);
endinterface

interface itps_result_if;
  import itps_pkg::*;

  logic                valid;
  logic                ready;
  logic                state_changed;
  logic [1:0]          power_level;
  logic [BRIGHT_W-1:0] display_brightness;
  logic [MS_W-1:0]     poll_interval_ms;
  logic                sleep_request_taken;

  modport source (output valid, state_changed, power_level, display_brightness,
                  poll_interval_ms, sleep_request_taken, input ready);
  modport sink   (input valid, state_changed, power_level, display_brightness,
                  poll_interval_ms, sleep_request_taken, output ready);
endinterface

// ----- sv/itps_cfg_regs.sv -----
module itps_cfg_regs
  import itps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // register file, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_after_ms         <= RST_DIM_AFTER;
      cfg.display_off_after_ms <= RST_OFF_AFTER;
      cfg.light_sleep_after_ms <= RST_SLEEP_AFTER;
      cfg.active_brightness    <= RST_ACTIVE_BRIGHT;
      cfg.dim_brightness       <= RST_DIM_BRIGHT;
      cfg.off_poll_interval_ms <= RST_OFF_POLL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_AFTER:     cfg.dim_after_ms         <= cfg_data[MS_W-1:0];
        REG_OFF_AFTER:     cfg.display_off_after_ms <= cfg_data[MS_W-1:0];
        REG_SLEEP_AFTER:   cfg.light_sleep_after_ms <= cfg_data[MS_W-1:0];
        REG_ACTIVE_BRIGHT: cfg.active_brightness    <= cfg_data[BRIGHT_W-1:0];
        REG_DIM_BRIGHT:    cfg.dim_brightness       <= cfg_data[BRIGHT_W-1:0];
        REG_OFF_POLL:      cfg.off_poll_interval_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/itps_core.sv -----
module itps_core
  import itps_pkg::*;
#(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  itps_event_if.sink    in_ch,
  itps_result_if.source out_ch
);

  localparam int CW = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

  // input register
  logic                  s1_valid;
  action_t               s1_action;
  logic [TIME_WIDTH-1:0] s1_now;
  logic                  s1_allowed;

  // machine state
  logic                  running;
  logic [TIME_WIDTH-1:0] last_time;
  level_t                level;
  logic                  pending;

  // result register
  logic                  o_valid;
  logic                  o_changed;
  level_t                o_level;
  logic [BRIGHT_W-1:0]   o_bright;
  logic [MS_W-1:0]       o_poll;
  logic                  o_taken;

  // next values
  logic                  running_next;
  logic [TIME_WIDTH-1:0] last_time_next;
  level_t                level_next;
  logic                  pending_next;
  logic                  changed;
  logic                  taken;
  logic [BRIGHT_W-1:0]   bright;
  logic [MS_W-1:0]       poll;

  logic                  advance;
  logic [CW-1:0]         now_ext;
  logic [TIME_WIDTH-1:0] idle;
  logic [CW-1:0]         idle_ext;
  level_t                idle_level;

  // handshake: the input register moves on whenever the result slot frees
  assign advance      = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;
  assign now_ext      = CW'(in_ch.now_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_action  <= action_t'(in_ch.action);
      s1_now     <= now_ext[TIME_WIDTH-1:0];
      s1_allowed <= in_ch.sleep_allowed;
    end
  end

  // wrapping idle time against the three thresholds
  assign idle     = s1_now - last_time;
  assign idle_ext = CW'(idle);

  always_comb begin
    if (idle_ext >= CW'(cfg.light_sleep_after_ms)) begin
      idle_level = LVL_SLEEP;
    end else if (idle_ext >= CW'(cfg.display_off_after_ms)) begin
      idle_level = LVL_OFF;
    end else if (idle_ext >= CW'(cfg.dim_after_ms)) begin
      idle_level = LVL_DIM;
    end else begin
      idle_level = LVL_ACTIVE;
    end
  end

  // next state
  always_comb begin
    running_next   = running;
    last_time_next = last_time;
    level_next     = level;
    pending_next   = pending;
    changed        = 1'b0;
    taken          = 1'b0;
    case (s1_action)
      ACT_ACTIVITY: begin
        if (!running) begin
          running_next   = 1'b1;
          last_time_next = s1_now;
          level_next     = LVL_ACTIVE;
          pending_next   = 1'b0;
        end else begin
          last_time_next = s1_now;
          pending_next   = 1'b0;
          level_next     = LVL_ACTIVE;
          changed        = (level != LVL_ACTIVE);
        end
      end
      ACT_UPDATE: begin
        if (!running) begin
          running_next   = 1'b1;
          last_time_next = s1_now;
          level_next     = LVL_ACTIVE;
          pending_next   = 1'b0;
        end else if (!s1_allowed) begin
          pending_next = 1'b0;
          level_next   = LVL_ACTIVE;
          changed      = (level != LVL_ACTIVE);
        end else if (level != LVL_SLEEP && idle_level != level) begin
          level_next   = idle_level;
          pending_next = (idle_level == LVL_SLEEP);
          changed      = 1'b1;
        end
      end
      ACT_CLAIM: begin
        taken        = pending;
        pending_next = 1'b0;
      end
      ACT_RESTART: begin
        changed        = (level != LVL_ACTIVE);
        running_next   = 1'b1;
        last_time_next = s1_now;
        level_next     = LVL_ACTIVE;
        pending_next   = 1'b0;
      end
      default: ;
    endcase
  end

  // outputs for the level after the event
  always_comb begin
    bright = '0;
    poll   = '0;
    case (level_next)
      LVL_ACTIVE: bright = cfg.active_brightness;
      LVL_DIM:    bright = cfg.dim_brightness;
      LVL_OFF:    poll   = cfg.off_poll_interval_ms;
      LVL_SLEEP:  ;
      default:    ;
    endcase
  end

  // state update on each transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      last_time <= '0;
      level     <= LVL_ACTIVE;
      pending   <= 1'b0;
    end else if (advance) begin
      running   <= running_next;
      last_time <= last_time_next;
      level     <= level_next;
      pending   <= pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_changed <= changed;
      o_level   <= level_next;
      o_bright  <= bright;
      o_poll    <= poll;
      o_taken   <= taken;
    end
  end

  assign out_ch.valid               = o_valid;
  assign out_ch.state_changed       = o_changed;
  assign out_ch.power_level         = o_level;
  assign out_ch.display_brightness  = o_bright;
  assign out_ch.poll_interval_ms    = o_poll;
  assign out_ch.sleep_request_taken = o_taken;

  // a pending request only exists in light sleep
  a_pending_in_sleep: assert property (@(posedge clk) disable iff (rst)
    pending |-> level == LVL_SLEEP)
    else $error("sleep request pending outside light sleep");

  // before start the machine rests in active
  a_idle_before_start: assert property (@(posedge clk) disable iff (rst)
    !running |-> (level == LVL_ACTIVE && !pending))
    else $error("state moved before start");

  // a held result reports the current level
  a_result_level: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_level == level)
    else $error("result level differs from state");

  // a claim reports the request that was pending
  a_claim_taken: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_action == ACT_CLAIM) |=> o_taken == $past(pending))
    else $error("claim result wrong");

  // only a claim reports a taken request
  a_taken_only_claim: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_action != ACT_CLAIM) |=> !o_taken)
    else $error("request taken outside a claim");

endmodule

// ----- sv/idle_timeout_power_state.sv -----
// channel   modport  payload                                          transfer
// in_ch     sink     action, now_ms, sleep_allowed                    valid && ready
// out_ch    source   state_changed, power_level, display_brightness,  valid && ready
//                    poll_interval_ms, sleep_request_taken
// cfg       write    cfg_we, cfg_index, cfg_data                      cfg_we
//
// One event per cycle while the result is taken or the result register is empty.
// The event goes through an input register, then one pass of subtract, three
// compares and the level update, then the result register.
// Reset (synchronous, rst high) stops the machine, clears the level to active
// and loads the register reset values.
// A stalled result holds; the input register still frees when the result is taken.
module idle_timeout_power_state
  import itps_pkg::*;
#(
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  itps_event_if.sink            in_ch,
  itps_result_if.source         out_ch
);

  cfg_t cfg;

  // configuration registers
  itps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // event processing
  itps_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- tb/idle_timeout_power_state_tb.sv -----
`timescale 1ns / 1ps

module idle_timeout_power_state_tb;
  import itps_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    action_t         action;
    logic [MS_W-1:0] now_ms;
    logic            sleep_allowed;
  } power_event_t;

  typedef struct packed {
    logic                state_changed;
    level_t              power_level;
    logic [BRIGHT_W-1:0] display_brightness;
    logic [MS_W-1:0]     poll_interval_ms;
    logic                sleep_request_taken;
  } power_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  itps_event_if  ev_ch ();
  itps_result_if res_ch ();

  idle_timeout_power_state dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (ev_ch),
    .out_ch    (res_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the block state and registers
  cfg_t            model_cfg;
  logic            model_running;
  logic [MS_W-1:0] model_last_activity;
  level_t          model_level;
  logic            model_sleep_req;

  power_event_t  pending_events[$];
  power_result_t expected_results[$];

  int unsigned failures;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          stall_request;
  bit          no_gaps;
  bit          event_sent;

  // stimulus generator timeline
  logic [MS_W-1:0] gen_now;
  logic [MS_W-1:0] gen_anchor;

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    failures++;
  endtask

  function automatic void start_model(logic [MS_W-1:0] now_ms);
    model_running       = 1'b1;
    model_last_activity = now_ms;
    model_level         = LVL_ACTIVE;
    model_sleep_req     = 1'b0;
  endfunction

  function automatic logic move_level(level_t next_level);
    if (model_level == next_level) return 1'b0;
    model_level     = next_level;
    model_sleep_req = (next_level == LVL_SLEEP);
    return 1'b1;
  endfunction

  // next power level and outputs for one event
  function automatic power_result_t predict_power_step(power_event_t ev);
    power_result_t   res;
    level_t          target;
    logic [MS_W-1:0] idle_ms;
    res.state_changed       = 1'b0;
    res.sleep_request_taken = 1'b0;
    idle_ms = ev.now_ms - model_last_activity;
    case (ev.action)
      ACT_ACTIVITY: begin
        if (!model_running) begin
          start_model(ev.now_ms);
        end else begin
          model_last_activity = ev.now_ms;
          model_sleep_req     = 1'b0;
          res.state_changed   = move_level(LVL_ACTIVE);
        end
      end
      ACT_UPDATE: begin
        if (!model_running) begin
          start_model(ev.now_ms);
        end else if (!ev.sleep_allowed) begin
          model_sleep_req   = 1'b0;
          res.state_changed = move_level(LVL_ACTIVE);
        end else if (model_level != LVL_SLEEP) begin
          if (idle_ms >= model_cfg.light_sleep_after_ms)      target = LVL_SLEEP;
          else if (idle_ms >= model_cfg.display_off_after_ms) target = LVL_OFF;
          else if (idle_ms >= model_cfg.dim_after_ms)         target = LVL_DIM;
          else                                                target = LVL_ACTIVE;
          res.state_changed = move_level(target);
        end
      end
      ACT_CLAIM: begin
        res.sleep_request_taken = model_sleep_req;
        model_sleep_req         = 1'b0;
      end
      default: begin
        res.state_changed = (model_level != LVL_ACTIVE);
        start_model(ev.now_ms);
      end
    endcase
    res.power_level = model_level;
    case (model_level)
      LVL_ACTIVE: res.display_brightness = model_cfg.active_brightness;
      LVL_DIM:    res.display_brightness = model_cfg.dim_brightness;
      default:    res.display_brightness = '0;
    endcase
    res.poll_interval_ms = (model_level == LVL_OFF) ? model_cfg.off_poll_interval_ms : '0;
    return res;
  endfunction

  // event driver: holds each item until its transfer
  always @(negedge clk) begin
    power_event_t ev;
    if (rst) begin
      ev_ch.valid <= 1'b0;
    end else if (!ev_ch.valid || event_sent) begin
      event_sent = 1'b0;
      if (pending_events.size() != 0 && (no_gaps || $urandom_range(99) >= 12)) begin
        ev = pending_events.pop_front();
        ev_ch.valid         <= 1'b1;
        ev_ch.action        <= ev.action;
        ev_ch.now_ms        <= ev.now_ms;
        ev_ch.sleep_allowed <= ev.sleep_allowed;
      end else begin
        ev_ch.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      stall_left    = HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= no_gaps || $urandom_range(99) >= 12;
    end
  end

  // input transfer: predict the result
  always @(posedge clk) begin
    power_event_t ev;
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      ev.action        = action_t'(ev_ch.action);
      ev.now_ms        = ev_ch.now_ms;
      ev.sleep_allowed = ev_ch.sleep_allowed;
      expected_results.push_back(predict_power_step(ev));
      event_sent = 1'b1;
    end
  end

  // output transfer: compare with the oldest prediction
  always @(posedge clk) begin
    power_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_error("result with no event pending");
      end else begin
        want = expected_results.pop_front();
        if (res_ch.state_changed !== want.state_changed)
          report_error($sformatf("state_changed got %0b expected %0b",
                                 res_ch.state_changed, want.state_changed));
        if (res_ch.power_level !== want.power_level)
          report_error($sformatf("power_level got %0d expected %0d",
                                 res_ch.power_level, want.power_level));
        if (res_ch.display_brightness !== want.display_brightness)
          report_error($sformatf("display_brightness got %0d expected %0d",
                                 res_ch.display_brightness, want.display_brightness));
        if (res_ch.poll_interval_ms !== want.poll_interval_ms)
          report_error($sformatf("poll_interval_ms got %0d expected %0d",
                                 res_ch.poll_interval_ms, want.poll_interval_ms));
        if (res_ch.sleep_request_taken !== want.sleep_request_taken)
          report_error($sformatf("sleep_request_taken got %0b expected %0b",
                                 res_ch.sleep_request_taken, want.sleep_request_taken));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("idle_timeout_power_state test failed");
        $finish;
      end
    end
  end

  task automatic push_event(action_t action, logic [MS_W-1:0] now_ms, logic allowed);
    power_event_t ev;
    ev.action        = action;
    ev.now_ms        = now_ms;
    ev.sleep_allowed = allowed;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_DIM_AFTER:     model_cfg.dim_after_ms         = value;
      REG_OFF_AFTER:     model_cfg.display_off_after_ms = value;
      REG_SLEEP_AFTER:   model_cfg.light_sleep_after_ms = value;
      REG_ACTIVE_BRIGHT: model_cfg.active_brightness    = value[BRIGHT_W-1:0];
      REG_DIM_BRIGHT:    model_cfg.dim_brightness       = value[BRIGHT_W-1:0];
      REG_OFF_POLL:      model_cfg.off_poll_interval_ms = value;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [MS_W-1:0] dim_ms, logic [MS_W-1:0] off_ms,
                             logic [MS_W-1:0] sleep_ms, logic [BRIGHT_W-1:0] act_bright,
                             logic [BRIGHT_W-1:0] dim_bright, logic [MS_W-1:0] poll_ms);
    write_reg(REG_DIM_AFTER, dim_ms);
    write_reg(REG_OFF_AFTER, off_ms);
    write_reg(REG_SLEEP_AFTER, sleep_ms);
    write_reg(REG_ACTIVE_BRIGHT, {{(CFG_DATA_W-BRIGHT_W){1'b0}}, act_bright});
    write_reg(REG_DIM_BRIGHT, {{(CFG_DATA_W-BRIGHT_W){1'b0}}, dim_bright});
    write_reg(REG_OFF_POLL, poll_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block until every queued event has produced its result
  task automatic wait_idle();
    while (pending_events.size() != 0 || ev_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly plausible timelines around the thresholds, some wild jumps
  task automatic queue_random_events(int count);
    logic [MS_W-1:0] span;
    logic [MS_W-1:0] thr;
    action_t         action;
    int unsigned     pick;
    span = model_cfg.light_sleep_after_ms;
    if (model_cfg.display_off_after_ms > span) span = model_cfg.display_off_after_ms;
    if (model_cfg.dim_after_ms > span) span = model_cfg.dim_after_ms;
    span = span / 3 + 16;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: gen_now += $urandom_range(0, 15);
        1: gen_now += $urandom_range(0, span);
        2: gen_now += $urandom_range(0, span / 8);
        3: gen_now = $urandom;
        default: begin
          case ($urandom_range(0, 2))
            0:       thr = model_cfg.dim_after_ms;
            1:       thr = model_cfg.display_off_after_ms;
            default: thr = model_cfg.light_sleep_after_ms;
          endcase
          gen_now = gen_anchor + thr - $urandom_range(0, 1);
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 15)      action = ACT_ACTIVITY;
      else if (pick < 75) action = ACT_UPDATE;
      else if (pick < 88) action = ACT_CLAIM;
      else                action = ACT_RESTART;
      if (action == ACT_ACTIVITY || action == ACT_RESTART) gen_anchor = gen_now;
      push_event(action, gen_now, $urandom_range(99) >= 8);
    end
  endtask

  initial begin
    logic [MS_W-1:0] t_dim;
    logic [MS_W-1:0] t_off;
    logic [MS_W-1:0] t_sleep;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    ev_ch.valid         = 1'b0;
    ev_ch.action        = '0;
    ev_ch.now_ms        = '0;
    ev_ch.sleep_allowed = 1'b0;
    res_ch.ready        = 1'b0;
    failures            = 0;
    quiet_cycles        = 0;
    stall_left          = 0;
    stall_request       = 1'b0;
    no_gaps             = 1'b0;
    event_sent          = 1'b0;
    gen_now             = '0;
    gen_anchor          = '0;
    model_cfg.dim_after_ms         = RST_DIM_AFTER;
    model_cfg.display_off_after_ms = RST_OFF_AFTER;
    model_cfg.light_sleep_after_ms = RST_SLEEP_AFTER;
    model_cfg.active_brightness    = RST_ACTIVE_BRIGHT;
    model_cfg.dim_brightness       = RST_DIM_BRIGHT;
    model_cfg.off_poll_interval_ms = RST_OFF_POLL;
    model_running       = 1'b0;
    model_last_activity = '0;
    model_level         = LVL_ACTIVE;
    model_sleep_req     = 1'b0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: claim before start, update performs the start
    push_event(ACT_CLAIM,  32'd5,          1'b1);
    push_event(ACT_UPDATE, 32'hFFFF_FFFF,  1'b0);
    // threshold edges with idle time wrapping past zero
    push_event(ACT_UPDATE, 32'd29998,      1'b1);
    push_event(ACT_UPDATE, 32'd29999,      1'b1);
    push_event(ACT_UPDATE, 32'd59999,      1'b1);
    push_event(ACT_CLAIM,  32'd0,          1'b1);
    push_event(ACT_UPDATE, 32'd299999,     1'b1);
    // light sleep holds, request claimed once
    push_event(ACT_UPDATE, 32'd0,          1'b1);
    push_event(ACT_CLAIM,  32'd0,          1'b0);
    push_event(ACT_CLAIM,  32'd0,          1'b1);
    push_event(ACT_UPDATE, 32'hFFFF_FFFF,  1'b1);
    push_event(ACT_ACTIVITY, 32'h8000_0000, 1'b0);
    push_event(ACT_UPDATE, 32'h8004_93E0,  1'b1);
    // sleep not allowed forces active and drops the request
    push_event(ACT_UPDATE, 32'h8004_93E0,  1'b0);
    push_event(ACT_CLAIM,  32'h8004_93E0,  1'b1);
    push_event(ACT_UPDATE, 32'h8000_EA60,  1'b1);
    // restart from display off, then from active
    push_event(ACT_RESTART, 32'd0,         1'b1);
    push_event(ACT_RESTART, 32'd0,         1'b0);
    push_event(ACT_UPDATE, 32'd30000,      1'b1);
    push_event(ACT_ACTIVITY, 32'hFFFF_FF00, 1'b1);
    push_event(ACT_UPDATE, 32'h0000_7500,  1'b1);
    push_event(ACT_UPDATE, 32'h0004_9300,  1'b1);
    push_event(ACT_RESTART, 32'h0004_9300, 1'b1);
    push_event(ACT_ACTIVITY, 32'h0004_9300, 1'b1);
    wait_idle();

    // register reset values
    gen_now    = 32'h0004_9300;
    gen_anchor = gen_now;
    queue_random_events(200);
    wait_idle();

    // zero thresholds, with the receiver held off to back up the pipe
    load_config('0, '0, '0, 8'h00, 8'hFF, 32'hFFFF_FFFF);
    stall_request = 1'b1;
    queue_random_events(150);
    wait_idle();

    // maximum thresholds, back to back transfers
    load_config('1, '1, '1, 8'hFF, 8'h00, 32'h0000_0000);
    no_gaps = 1'b1;
    queue_random_events(150);
    wait_idle();
    no_gaps = 1'b0;

    // random settings: ordered small thresholds or fully random ones
    for (int phase = 0; phase < 4; phase++) begin
      if (phase % 2 == 0) begin
        t_dim   = $urandom_range(0, 2000);
        t_off   = t_dim + $urandom_range(0, 2000);
        t_sleep = t_off + $urandom_range(0, 4000);
      end else begin
        t_dim   = $urandom;
        t_off   = $urandom;
        t_sleep = $urandom;
      end
      load_config(t_dim, t_off, t_sleep, BRIGHT_W'($urandom), BRIGHT_W'($urandom),
                  $urandom);
      queue_random_events(120);
      wait_idle();
    end

    if (failures == 0) begin
      $display("idle_timeout_power_state test passed");
    end else begin
      $display("idle_timeout_power_state test failed");
    end
    $finish;
  end

endmodule

// ----- idle_timeout_power_state.f -----
sv/itps_pkg.sv
sv/itps_if.sv
sv/itps_cfg_regs.sv
sv/itps_core.sv
sv/idle_timeout_power_state.sv
tb/idle_timeout_power_state_tb.sv
